@@ src/srgc_pkg.sv @@
// ----------------------------------------------------------------------------
// srgc_pkg
// Shared types, constants and elaboration-time tables for the sonar range
// gain correction pipeline.
// ----------------------------------------------------------------------------
package srgc_pkg;

  localparam int AMPLITUDE_BITS  = 16;
  localparam int LOG_TABLE_DEPTH = 256;

  localparam int OUT_W       = 16;
  localparam int RANGE_W     = 17;
  localparam int REF_W       = 13;
  localparam int GAIN_REG_W  = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAC_W      = 16;
  localparam int EXP_W       = 5;
  localparam int LOG_W       = 21;
  localparam int ENTRY_W     = 17;
  localparam int IDX_W       = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int GSUM_W      = 22;
  localparam int G_W         = 15;
  localparam int FAC_W       = 31;
  localparam int FAC_Q       = 30;
  localparam int FAC_STEPS   = 16;
  localparam int N_LIMIT     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SPREADING  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ABSORPTION = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE  = CFG_INDEX_W'(2);

  localparam logic [GAIN_REG_W-1:0] SPREADING_RST  = GAIN_REG_W'(5120);
  localparam logic [GAIN_REG_W-1:0] ABSORPTION_RST = GAIN_REG_W'(0);
  localparam logic [REF_W-1:0]      REF_MIN        = REF_W'(100);

  localparam logic [GSUM_W-1:0] GAIN_CAP    = GSUM_W'(25600);
  localparam logic [14:0]       LOG10_2_Q16 = 15'd19728;
  localparam logic [21:0]       LOG2_10_Q32 = 22'd2786635;
  // floor(x/1600) as floor((x>>6) * ceil(2^30/25) >> 30), exact for x below 2^31
  localparam int                ABS_PRE     = 6;
  localparam int                ABS_SHIFT   = 30;
  localparam logic [25:0]       ABS_RECIP   = 26'd42949673;

  localparam logic [FAC_W-1:0] FAC_ONE = FAC_W'(1) << FAC_Q;

  typedef struct packed {
    logic [GAIN_REG_W-1:0] spreading;
    logic [GAIN_REG_W-1:0] absorption;
    logic [REF_W-1:0]      reference;
  } cfg_t;

  typedef struct packed {
    logic [AMPLITUDE_BITS-1:0] amp;
    logic                      bypass;
    logic [RANGE_W-1:0]        rng;
    logic [LOG_W-1:0]          d;
  } log_out_t;

  typedef struct packed {
    logic [AMPLITUDE_BITS-1:0] amp;
    logic                      bypass;
    logic [EXP_W-1:0]          n;
    logic [FRAC_W-1:0]         q;
  } gain_out_t;

  typedef struct packed {
    logic [OUT_W-1:0] corrected;
    logic             applied;
  } res_t;

  typedef logic [ENTRY_W-1:0] log_tab_t [0:LOG_TABLE_DEPTH];
  typedef logic [FAC_W-1:0]   fac_tab_t [1:FAC_STEPS];

  // log2(1 + k/depth) in Q16 by repeated Q30 squaring
  function automatic logic [ENTRY_W-1:0] log_entry(int k);
    logic [63:0]        y;
    logic [ENTRY_W-1:0] res;
    res = '0;
    if (k >= LOG_TABLE_DEPTH) begin
      return ENTRY_W'(65536);
    end
    y = (64'd1 << 30) + ((64'(k) << 30) / LOG_TABLE_DEPTH);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      res = {res[ENTRY_W-2:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t tab;
    for (int k = 0; k <= LOG_TABLE_DEPTH; k++) begin
      tab[k] = log_entry(k);
    end
    return tab;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > rem) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-j) in Q30 for j = 1 .. FAC_STEPS
  function automatic fac_tab_t build_fac_tab();
    fac_tab_t    tab;
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 1; j <= FAC_STEPS; j++) begin
      c = isqrt64(c << 30);
      tab[j] = c[FAC_W-1:0];
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam fac_tab_t FAC_TAB = build_fac_tab();

endpackage

@@ src/sonar_range_gain_correction.sv @@
// ----------------------------------------------------------------------------
// sonar_range_gain_correction
// Range-dependent sonar gain: spreading plus absorption gain in 1/256 dB,
// applied to each echo sample with saturation to the amplitude maximum.
// ----------------------------------------------------------------------------
// One sample item is taken every clock while the pipeline is not stalled full,
// and its result passes through four stages of log2 (normalise, table,
// interpolate, difference), four of gain arithmetic, and eighteen of exponent,
// where the sixteen sequential Q30 multiplies by 2^(2^-j) set the depth. Every
// stage has its own valid bit and a stalled output only holds the items behind
// it, so bubbles close up and input is still taken while a result waits, until
// every stage is full. The log table (257 entries) and the exponent constants
// are built at elaboration. Gain is capped at 100 dB. Samples nearer than the
// reference range pass through unchanged with the flag low. Configuration
// writes are taken at once and must only be made while the pipeline is empty.
module sonar_range_gain_correction (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [srgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] sample_amplitude, [32:16] sample_range, [39:33] zero
  input  logic [39:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] corrected_amplitude
  output logic [15:0]                       m_axis_tdata,
  // [0] gain_applied
  output logic                              m_axis_tuser
);

  srgc_pkg::cfg_t       cfg;
  srgc_pkg::log_out_t   log_item;
  srgc_pkg::gain_out_t  gain_item;
  srgc_pkg::res_t       res;
  logic                 log_valid;
  logic                 log_ready;
  logic                 gain_valid;
  logic                 gain_ready;
  logic [srgc_pkg::REF_W-1:0] ref_wr;

  assign cfg_ready = 1'b1;
  assign ref_wr    = cfg_data[srgc_pkg::REF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spreading  <= srgc_pkg::SPREADING_RST;
      cfg.absorption <= srgc_pkg::ABSORPTION_RST;
      cfg.reference  <= srgc_pkg::REF_MIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        srgc_pkg::REG_SPREADING:  cfg.spreading  <= cfg_data[srgc_pkg::GAIN_REG_W-1:0];
        srgc_pkg::REG_ABSORPTION: cfg.absorption <= cfg_data[srgc_pkg::GAIN_REG_W-1:0];
        // reference below one metre is held at one metre
        srgc_pkg::REG_REFERENCE:
          cfg.reference <= (ref_wr < srgc_pkg::REF_MIN) ? srgc_pkg::REF_MIN : ref_wr;
        default: ;
      endcase
    end
  end

  srgc_log u_log (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_amp    (s_axis_tdata[srgc_pkg::AMPLITUDE_BITS-1:0]),
    .in_rng    (s_axis_tdata[16 +: srgc_pkg::RANGE_W]),
    .out_valid (log_valid),
    .out_ready (log_ready),
    .out_item  (log_item)
  );

  srgc_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (log_valid),
    .in_ready  (log_ready),
    .in_item   (log_item),
    .out_valid (gain_valid),
    .out_ready (gain_ready),
    .out_item  (gain_item)
  );

  srgc_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gain_valid),
    .in_ready  (gain_ready),
    .in_item   (gain_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (res)
  );

  assign m_axis_tdata = res.corrected;
  assign m_axis_tuser = res.applied;

`ifndef SYNTH
  // pipeline comes out of reset empty
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // input can only be held off by a result waiting at the output
  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // stored reference never below one metre
  assert property (@(posedge clk) disable iff (rst) cfg.reference >= srgc_pkg::REF_MIN)
    else $error("reference range below minimum");
`endif

endmodule

@@ src/srgc_log.sv @@
// ----------------------------------------------------------------------------
// srgc_log
// Four-stage log2 front end: normalise range and reference, table lookup,
// interpolation, and log difference.
// ----------------------------------------------------------------------------
module srgc_log (
  input  logic                              clk,
  input  logic                              rst,
  input  srgc_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srgc_pkg::AMPLITUDE_BITS-1:0] in_amp,
  input  logic [srgc_pkg::RANGE_W-1:0]      in_rng,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srgc_pkg::log_out_t                out_item
);

  localparam int NSTAGE = 4;
  localparam int PR_W   = srgc_pkg::ENTRY_W + srgc_pkg::FRAC_W;
  localparam int T_W    = srgc_pkg::FRAC_W + srgc_pkg::IDX_W;

  typedef struct packed {
    logic [srgc_pkg::EXP_W-1:0]  e;
    logic [srgc_pkg::FRAC_W-1:0] f;
  } norm_t;

  typedef struct packed {
    logic [srgc_pkg::ENTRY_W-1:0] lo;
    logic [srgc_pkg::ENTRY_W-1:0] diff;
    logic [srgc_pkg::FRAC_W-1:0]  rem;
  } frac_t;

  function automatic norm_t normalise(logic [srgc_pkg::RANGE_W-1:0] x);
    norm_t                                          nv;
    logic [srgc_pkg::RANGE_W+srgc_pkg::FRAC_W-1:0] sh;
    nv.e = '0;
    for (int i = 0; i < srgc_pkg::RANGE_W; i++) begin
      if (x[i]) nv.e = srgc_pkg::EXP_W'(i);
    end
    // leading one lands on bit FRAC_W, the bits below are the fraction
    sh = {{srgc_pkg::FRAC_W{1'b0}}, x} << (srgc_pkg::FRAC_W - int'(nv.e));
    nv.f = sh[srgc_pkg::FRAC_W-1:0];
    return nv;
  endfunction

  function automatic frac_t lookup(logic [srgc_pkg::FRAC_W-1:0] f);
    logic [T_W-1:0]             t;
    logic [srgc_pkg::IDX_W-1:0] k;
    frac_t                      fv;
    t       = T_W'(f) * T_W'(srgc_pkg::LOG_TABLE_DEPTH);
    k       = t[T_W-1:srgc_pkg::FRAC_W];
    fv.rem  = t[srgc_pkg::FRAC_W-1:0];
    fv.lo   = srgc_pkg::LOG_TAB[k];
    fv.diff = srgc_pkg::LOG_TAB[k + 1'b1] - fv.lo;
    return fv;
  endfunction

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   rdy;

  assign rdy[NSTAGE] = out_ready;
  for (genvar k = 0; k < NSTAGE; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: normalise
  logic [srgc_pkg::AMPLITUDE_BITS-1:0] amp1;
  logic [srgc_pkg::RANGE_W-1:0]        rng1;
  logic                                byp1;
  norm_t                               nr1;
  norm_t                               nref1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      amp1  <= in_amp;
      rng1  <= in_rng;
      byp1  <= in_rng < srgc_pkg::RANGE_W'(cfg.reference);
      nr1   <= normalise(in_rng);
      nref1 <= normalise(srgc_pkg::RANGE_W'(cfg.reference));
    end
  end

  // stage 2: table lookup
  logic [srgc_pkg::AMPLITUDE_BITS-1:0] amp2;
  logic [srgc_pkg::RANGE_W-1:0]        rng2;
  logic                                byp2;
  logic [srgc_pkg::EXP_W-1:0]          er2;
  logic [srgc_pkg::EXP_W-1:0]          eref2;
  frac_t                               fr2;
  frac_t                               fref2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      amp2  <= amp1;
      rng2  <= rng1;
      byp2  <= byp1;
      er2   <= nr1.e;
      eref2 <= nref1.e;
      fr2   <= lookup(nr1.f);
      fref2 <= lookup(nref1.f);
    end
  end

  // stage 3: interpolate
  logic [PR_W-1:0]               pr_r;
  logic [PR_W-1:0]               pr_ref;
  logic [srgc_pkg::LOG_W-1:0]    lr_next;
  logic [srgc_pkg::LOG_W-1:0]    lref_next;

  always_comb begin
    pr_r      = PR_W'(fr2.diff) * PR_W'(fr2.rem);
    pr_ref    = PR_W'(fref2.diff) * PR_W'(fref2.rem);
    lr_next   = {er2, srgc_pkg::FRAC_W'(0)} + srgc_pkg::LOG_W'(fr2.lo)
              + srgc_pkg::LOG_W'(pr_r >> srgc_pkg::FRAC_W);
    lref_next = {eref2, srgc_pkg::FRAC_W'(0)} + srgc_pkg::LOG_W'(fref2.lo)
              + srgc_pkg::LOG_W'(pr_ref >> srgc_pkg::FRAC_W);
  end

  logic [srgc_pkg::AMPLITUDE_BITS-1:0] amp3;
  logic [srgc_pkg::RANGE_W-1:0]        rng3;
  logic                                byp3;
  logic [srgc_pkg::LOG_W-1:0]          lr3;
  logic [srgc_pkg::LOG_W-1:0]          lref3;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      amp3  <= amp2;
      rng3  <= rng2;
      byp3  <= byp2;
      lr3   <= lr_next;
      lref3 <= lref_next;
    end
  end

  // stage 4: log difference, clamped at zero
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_item.amp    <= amp3;
      out_item.rng    <= rng3;
      out_item.bypass <= byp3;
      out_item.d      <= (lr3 > lref3) ? lr3 - lref3 : '0;
    end
  end

endmodule

@@ src/srgc_gain.sv @@
// ----------------------------------------------------------------------------
// srgc_gain
// Four-stage gain arithmetic: spreading and absorption terms, sum with cap,
// and conversion of the gain to a base-two exponent.
// ----------------------------------------------------------------------------
module srgc_gain (
  input  logic                  clk,
  input  logic                  rst,
  input  srgc_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srgc_pkg::log_out_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srgc_pkg::gain_out_t   out_item
);

  localparam int NSTAGE = 4;
  localparam int M1_W   = srgc_pkg::GAIN_REG_W + srgc_pkg::LOG_W;
  localparam int S_W    = M1_W + 15;
  localparam int A1_W   = srgc_pkg::GAIN_REG_W + srgc_pkg::RANGE_W;
  localparam int A2_W   = A1_W - srgc_pkg::ABS_PRE + 26;
  localparam int PP_W   = srgc_pkg::G_W + 22;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   rdy;

  assign rdy[NSTAGE] = out_ready;
  for (genvar k = 0; k < NSTAGE; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: first products
  logic [srgc_pkg::RANGE_W-1:0]        excess;
  logic [srgc_pkg::AMPLITUDE_BITS-1:0] amp1;
  logic                                byp1;
  logic [M1_W-1:0]                     m1;
  logic [A1_W-1:0]                     a1;

  assign excess = in_item.bypass ? '0
                : in_item.rng - srgc_pkg::RANGE_W'(cfg.reference);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      amp1 <= in_item.amp;
      byp1 <= in_item.bypass;
      m1   <= M1_W'(cfg.spreading) * M1_W'(in_item.d);
      a1   <= A1_W'(cfg.absorption) * A1_W'(excess);
    end
  end

  // stage 2: log10 scaling and divide by 1600 through the reciprocal
  logic [srgc_pkg::AMPLITUDE_BITS-1:0] amp2;
  logic                                byp2;
  logic [S_W-1:0]                      s2;
  logic [A2_W-1:0]                     a2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      amp2 <= amp1;
      byp2 <= byp1;
      s2   <= S_W'(m1) * S_W'(srgc_pkg::LOG10_2_Q16);
      a2   <= A2_W'(a1[A1_W-1:srgc_pkg::ABS_PRE]) * A2_W'(srgc_pkg::ABS_RECIP);
    end
  end

  // stage 3: round, sum, cap
  logic [S_W:0]                 s_rnd;
  logic [srgc_pkg::GSUM_W-1:0]  gsum;
  logic [srgc_pkg::AMPLITUDE_BITS-1:0] amp3;
  logic                         byp3;
  logic [srgc_pkg::G_W-1:0]     g3;

  always_comb begin
    s_rnd = (S_W+1)'(s2) + ((S_W+1)'(1) << 31);
    gsum  = srgc_pkg::GSUM_W'(s_rnd >> 32) + srgc_pkg::GSUM_W'(a2 >> srgc_pkg::ABS_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      amp3 <= amp2;
      byp3 <= byp2;
      g3   <= (gsum > srgc_pkg::GAIN_CAP) ? srgc_pkg::G_W'(srgc_pkg::GAIN_CAP)
                                          : gsum[srgc_pkg::G_W-1:0];
    end
  end

  // stage 4: exponent in Q16, split into integer and fraction
  logic [PP_W-1:0] pp;

  assign pp = PP_W'(g3) * PP_W'(srgc_pkg::LOG2_10_Q32);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_item.amp    <= amp3;
      out_item.bypass <= byp3;
      out_item.n      <= pp[PP_W-1:32];
      out_item.q      <= pp[31:16];
    end
  end

endmodule

@@ src/srgc_exp.sv @@
// ----------------------------------------------------------------------------
// srgc_exp
// Exponent chain: sixteen stages of conditional Q30 multiplies by 2^(2^-j),
// the amplitude product, then the integer shift and saturation.
// ----------------------------------------------------------------------------
module srgc_exp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srgc_pkg::gain_out_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srgc_pkg::res_t        out_item
);

  localparam int STEPS  = srgc_pkg::FAC_STEPS;
  localparam int NSTAGE = STEPS + 2;
  localparam int PROD_W = srgc_pkg::AMPLITUDE_BITS + srgc_pkg::FAC_W;
  localparam int AMP_W  = srgc_pkg::AMPLITUDE_BITS;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   rdy;

  assign rdy[NSTAGE] = out_ready;
  for (genvar k = 0; k < NSTAGE; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // entry s+1 is the register of step s
  logic [AMP_W-1:0]                  amp_a [1:STEPS];
  logic                              byp_a [1:STEPS];
  logic [srgc_pkg::EXP_W-1:0]        n_a   [1:STEPS];
  logic [srgc_pkg::FRAC_W-1:0]       q_a   [1:STEPS];
  logic [srgc_pkg::FAC_W-1:0]        fac_a [1:STEPS];

  // fraction bits are taken from the top down, in the order of truncation
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [AMP_W-1:0]             amp_i;
    logic                         byp_i;
    logic [srgc_pkg::EXP_W-1:0]   n_i;
    logic [srgc_pkg::FRAC_W-1:0]  q_i;
    logic [srgc_pkg::FAC_W-1:0]   fac_i;
    logic [2*srgc_pkg::FAC_W-1:0] prd;
    logic [srgc_pkg::FAC_W-1:0]   fnext;

    if (s == 0) begin : g_head
      assign amp_i = in_item.amp;
      assign byp_i = in_item.bypass;
      assign n_i   = in_item.n;
      assign q_i   = in_item.q;
      assign fac_i = srgc_pkg::FAC_ONE;
    end else begin : g_body
      assign amp_i = amp_a[s];
      assign byp_i = byp_a[s];
      assign n_i   = n_a[s];
      assign q_i   = q_a[s];
      assign fac_i = fac_a[s];
    end

    assign prd   = (2*srgc_pkg::FAC_W)'(fac_i)
                 * (2*srgc_pkg::FAC_W)'(srgc_pkg::FAC_TAB[s+1]);
    assign fnext = q_i[STEPS-1-s]
                 ? prd[srgc_pkg::FAC_Q+srgc_pkg::FAC_W-1:srgc_pkg::FAC_Q] : fac_i;

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        amp_a[s+1] <= amp_i;
        byp_a[s+1] <= byp_i;
        n_a[s+1]   <= n_i;
        q_a[s+1]   <= q_i;
        fac_a[s+1] <= fnext;
      end
    end
  end

  // amplitude times fractional factor
  logic [AMP_W-1:0]           amp_p;
  logic                       byp_p;
  logic [srgc_pkg::EXP_W-1:0] n_p;
  logic [PROD_W-1:0]          prod;

  always_ff @(posedge clk) begin
    if (rdy[STEPS]) begin
      amp_p <= amp_a[STEPS];
      byp_p <= byp_a[STEPS];
      n_p   <= n_a[STEPS];
      prod  <= PROD_W'(amp_a[STEPS]) * PROD_W'(fac_a[STEPS]);
    end
  end

  // integer part of the exponent and saturation
  logic [srgc_pkg::EXP_W-1:0] shamt;
  logic [PROD_W-1:0]          shv;
  logic [AMP_W-1:0]           val;

  always_comb begin
    shamt = srgc_pkg::EXP_W'(srgc_pkg::FAC_Q) - n_p;
    shv   = prod >> shamt;
    priority if (byp_p) begin
      val = amp_p;
    end else if (n_p > srgc_pkg::EXP_W'(srgc_pkg::N_LIMIT)) begin
      val = (amp_p != '0) ? {AMP_W{1'b1}} : '0;
    end else if (|shv[PROD_W-1:AMP_W]) begin
      val = {AMP_W{1'b1}};
    end else begin
      val = shv[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[STEPS+1]) begin
      out_item.corrected <= srgc_pkg::OUT_W'(val);
      out_item.applied   <= !byp_p;
    end
  end

endmodule

@@ sim/sonar_range_gain_correction_checker.sv @@
// ----------------------------------------------------------------------------
// sonar_range_gain_correction_checker
// Watches the configuration, sample and result channels, predicts the gain
// corrected amplitude of every accepted sample and compares results in order.
// ----------------------------------------------------------------------------
module sonar_range_gain_correction_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [srgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [39:0]                      s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [15:0]                      m_axis_tdata,
  input  logic                             m_axis_tuser,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic [15:0] amp;
    logic        applied;
  } corr_t;

  corr_t       corr_q[$];
  logic [63:0] log_frac [0:256];
  logic [63:0] root_step [1:16];
  logic [63:0] spread_r, absorb_r, ref_r;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] frac_log(int k);
    logic [63:0] y, res;
    res = 0;
    if (k >= 256) return 64'd65536;
    y = (64'd1 << 30) + ((64'(k) << 30) / 256);
    for (int i = 0; i < 16; i++) begin
      y   = (y * y) >> 30;
      res = res << 1;
      if (y >= (64'd1 << 31)) begin
        y   = y >> 1;
        res = res | 1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int          e;
    logic [63:0] f, t, k, rem, lo, hi;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    f   = ((x << 16) >> e) - 64'd65536;
    t   = f * 256;
    k   = t >> 16;
    rem = t & 64'hFFFF;
    lo  = log_frac[k];
    hi  = log_frac[k + 1];
    return (64'(e) << 16) + lo + (((hi - lo) * rem) >> 16);
  endfunction

  function automatic corr_t correct_sample(logic [15:0] amp, logic [16:0] rng);
    corr_t       o;
    logic [63:0] r, lr, lref, d, g, p, n, q, fac, val;
    r = 64'(rng);
    if (r < ref_r) begin
      o.amp     = amp;
      o.applied = 1'b0;
      return o;
    end
    lr   = log2_fix(r);
    lref = log2_fix(ref_r);
    d    = lr > lref ? lr - lref : 0;
    g    = (spread_r * d * 64'd19728 + (64'd1 << 31)) >> 32;
    g    = g + (absorb_r * (r - ref_r)) / 1600;
    if (g > 25600) g = 25600;
    p   = (g * 64'd2786635) >> 16;
    n   = p >> 16;
    q   = p & 64'hFFFF;
    fac = 64'd1 << 30;
    for (int i = 15; i >= 0; i--) begin
      if ((q >> i) & 1) fac = (fac * root_step[16 - i]) >> 30;
    end
    if (n > 16) begin
      val = amp != 0 ? 64'hFFFF : 0;
    end else begin
      val = (64'(amp) * fac) >> (30 - n);
      if (val > 64'hFFFF) val = 64'hFFFF;
    end
    o.amp     = val[15:0];
    o.applied = 1'b1;
    return o;
  endfunction

  initial begin
    logic [63:0] c;
    for (int k = 0; k <= 256; k++) log_frac[k] = frac_log(k);
    c = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      c            = int_sqrt(c << 30);
      root_step[j] = c;
    end
  end

  assign pending = corr_q.size();

  always @(posedge clk) begin
    corr_t exp_r;
    if (rst) begin
      spread_r   <= 64'd5120;
      absorb_r   <= 64'd0;
      ref_r      <= 64'd100;
      fail_count <= 0;
      corr_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srgc_pkg::REG_SPREADING: begin
            spread_r <= 64'(cfg_data[13:0]);
          end
          srgc_pkg::REG_ABSORPTION: begin
            absorb_r <= 64'(cfg_data[13:0]);
          end
          srgc_pkg::REG_REFERENCE: begin
            ref_r <= cfg_data[12:0] < 13'd100 ? 64'd100 : 64'(cfg_data[12:0]);
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        corr_q.push_back(correct_sample(s_axis_tdata[15:0], s_axis_tdata[32:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (corr_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result item: amp %0d applied %0b",
                     m_axis_tdata, m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = corr_q.pop_front();
          if (exp_r.amp !== m_axis_tdata || exp_r.applied !== m_axis_tuser) begin
            if (fail_count < 10)
              $display("mismatch: expected amp %0d applied %0b, got amp %0d applied %0b",
                       exp_r.amp, exp_r.applied, m_axis_tdata, m_axis_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/sonar_range_gain_correction_tb.sv @@
// ----------------------------------------------------------------------------
// sonar_range_gain_correction_tb
// Drives directed and random echo samples through several gain settings,
// with random idling on both streams; the checker judges every result.
// ----------------------------------------------------------------------------
module sonar_range_gain_correction_tb;

  // index with no register behind it
  localparam logic [srgc_pkg::CFG_INDEX_W-1:0] REG_UNKNOWN = srgc_pkg::CFG_INDEX_W'(3);

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [srgc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [srgc_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [39:0]                      s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [15:0]                      m_axis_tdata;
  logic                             m_axis_tuser;
  int                               fail_count;
  int                               pending;
  logic                             quiet;
  logic [12:0]                      cur_ref;

  sonar_range_gain_correction dut (.*);

  sonar_range_gain_correction_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stalls
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_sample(logic [15:0] amp, logic [16:0] rng);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, rng, amp};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [srgc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [srgc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == srgc_pkg::REG_REFERENCE)
      cur_ref = val[12:0] < 13'd100 ? 13'd100 : val[12:0];
  endtask

  function automatic logic [16:0] pick_range();
    case ($urandom_range(0, 3))
      0: return 17'($urandom_range(0, 131071));
      1: return 17'($urandom_range(0, 100000));
      2: return 17'(int'(cur_ref) + $urandom_range(0, 8) - 4);
      default: return 17'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [15:0] pick_amp();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 64));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd10240;
      2: return 16'($urandom);
      3: return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, 10240));
    endcase
  endfunction

  function automatic logic [15:0] pick_ref();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 99));
      1: return 16'd5000;
      2: return 16'($urandom);
      3: return 16'd100;
      default: return 16'($urandom_range(100, 5000));
    endcase
  endfunction

  initial begin
    rst           = 1'b1;
    quiet         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cur_ref       = 13'd100;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset settings: bypass edge, zero and full amplitude, range extremes
    send_sample(16'd0, 17'd0);
    send_sample(16'hFFFF, 17'd99);
    send_sample(16'hFFFF, 17'd100);
    send_sample(16'd1000, 17'd101);
    send_sample(16'd0, 17'd100000);
    send_sample(16'hFFFF, 17'h1FFFF);
    send_sample(16'd1, 17'h1FFFF);
    send_sample(16'd12345, 17'd1000);
    drain();

    // reference below one metre clamps, unknown index ignored, huge gain
    write_reg(srgc_pkg::REG_REFERENCE, 16'd5);
    write_reg(REG_UNKNOWN, 16'hFFFF);
    write_reg(srgc_pkg::REG_SPREADING, 16'hFFFF);
    write_reg(srgc_pkg::REG_ABSORPTION, 16'hFFFF);
    send_sample(16'd0, 17'h1FFFF);
    send_sample(16'd1, 17'h1FFFF);
    send_sample(16'd7, 17'd200);
    send_sample(16'hFFFF, 17'd99);
    send_sample(16'd500, 17'd100);
    drain();

    write_reg(srgc_pkg::REG_SPREADING, 16'd0);
    write_reg(srgc_pkg::REG_ABSORPTION, 16'd0);
    write_reg(srgc_pkg::REG_REFERENCE, 16'hFFFF);
    send_sample(16'hFFFF, 17'd8190);
    send_sample(16'hFFFF, 17'd8191);
    send_sample(16'hA5A5, 17'h1FFFF);
    drain();

    write_reg(srgc_pkg::REG_SPREADING, 16'd10240);
    write_reg(srgc_pkg::REG_ABSORPTION, 16'd8192);
    write_reg(srgc_pkg::REG_REFERENCE, 16'd5000);
    send_sample(16'd100, 17'd4999);
    send_sample(16'd100, 17'd5000);
    send_sample(16'd100, 17'd100000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1'b1;
      write_reg(srgc_pkg::REG_SPREADING, pick_gain());
      write_reg(srgc_pkg::REG_ABSORPTION, pick_gain());
      write_reg(srgc_pkg::REG_REFERENCE, pick_ref());
      for (int i = 0; i < 125; i++) send_sample(pick_amp(), pick_range());
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
